FILE: hw/rtl/tso_pkg.sv
// Shared types, constants and the sine table for the table sine oscillator.
package tso_pkg;

	localparam int TABLE_SIZE = 512;
	localparam int INDEX_BITS = 9;
	localparam int HALF_SIZE = TABLE_SIZE / 2;
	localparam int HALF_BITS = INDEX_BITS - 1;
	localparam int FRACTION_BITS = 16;
	localparam int PHASE_BITS = INDEX_BITS + FRACTION_BITS;
	localparam int SAMPLE_BITS = 16;
	localparam int SEED_BITS = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = 2;
	localparam int QUEUE_COUNT_BITS = QUEUE_PTR_BITS + 1;

	localparam logic [SEED_BITS-1:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] SAMPLE_AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PHASE_STEP,
		CFG_PHASE_START,
		CFG_WAVEFORM_MODE,
		CFG_NOISE_SEED
	} cfg_index_t;

	typedef enum logic {
		WAVE_SINE,
		WAVE_NOISE
	} wave_t;

	typedef struct packed {
		wave_t                    wave;
		logic [INDEX_BITS-1:0]    index;
		logic [FRACTION_BITS-1:0] frac;
		logic [SAMPLE_BITS-1:0]   noise;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef logic [HALF_SIZE-1:0][SAMPLE_BITS-1:0] sine_rom_t;

	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [64:0] sum;
		int n;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed({1'b0, x});
		for (n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) == 1) begin
				sum = sum - $signed({1'b0, term});
			end else begin
				sum = sum + $signed({1'b0, term});
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed({1'b0, ONE_Q30})) begin
			sum = $signed({1'b0, ONE_Q30});
		end
		return sum[63:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] a;
		int k;
		for (k = 0; k < HALF_SIZE; k++) begin
			q = (64'(4 * k)) / TABLE_SIZE;
			r = 64'(4 * k) - q * TABLE_SIZE;
			x = (HALF_PI_Q30 * r) / TABLE_SIZE;
			if (q[0]) begin
				x = HALF_PI_Q30 - x;
			end
			a = (sin_q30(x) * SAMPLE_AMP + (ONE_Q30 >> 1)) >> 30;
			rom[k] = a[SAMPLE_BITS-1:0];
		end
		return rom;
	endfunction

	// First half of the sine table; the second half is its negation.
	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hw/rtl/tso_front.sv
// Front end: configuration registers, phase accumulator, noise LFSR and request intake.
module tso_front import tso_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      sample_request,
	input  queue_status_t             status,
	output logic                      push,
	output cmd_t                      cmd
);

	logic [PHASE_BITS-1:0] step_q;
	logic [PHASE_BITS-1:0] acc_q;
	logic [SEED_BITS-1:0]  lfsr_q;
	wave_t                 mode_q;
	logic [PHASE_BITS-1:0] acc_next;
	logic [SEED_BITS-1:0]  lfsr_next;
	logic                  accept;

	assign in_ready = !status.full;
	assign accept = in_valid && in_ready;
	assign push = accept && sample_request;

	assign acc_next = acc_q + step_q;
	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	always_comb begin
		cmd.wave = mode_q;
		cmd.index = acc_next[PHASE_BITS-1:FRACTION_BITS];
		cmd.frac = acc_next[FRACTION_BITS-1:0];
		cmd.noise = lfsr_next[SEED_BITS-1:SEED_BITS-SAMPLE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			acc_q <= '0;
			lfsr_q <= SEED_BITS'(1);
			mode_q <= WAVE_SINE;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PHASE_STEP: begin
					step_q <= cfg_data[PHASE_BITS-1:0];
				end
				CFG_PHASE_START: begin
					acc_q <= {cfg_data[INDEX_BITS-1:0], {FRACTION_BITS{1'b0}}};
				end
				CFG_WAVEFORM_MODE: begin
					mode_q <= wave_t'(cfg_data[0]);
				end
				CFG_NOISE_SEED: begin
					lfsr_q <= (cfg_data[SEED_BITS-1:0] == '0) ? SEED_BITS'(1)
						: cfg_data[SEED_BITS-1:0];
				end
			endcase
		end else if (push) begin
			if (mode_q == WAVE_NOISE) begin
				lfsr_q <= lfsr_next;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

FILE: hw/rtl/tso_fifo.sv
// Short command queue between the front end and the sample pipeline.
module tso_fifo import tso_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          wr_data,
	input  logic          pop,
	output cmd_t          rd_data,
	output queue_status_t status
);

	cmd_t                        mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0]   rd_ptr_q;
	logic [QUEUE_COUNT_BITS-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign status.full = (count_q == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_COUNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_COUNT_BITS'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/tso_back.sv
// Back end: table lookup, interpolation multiply and output register.
module tso_back import tso_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  queue_status_t                 status,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_value
);

	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = DIFF_BITS + FRACTION_BITS + 1;

	logic                            en;
	logic [INDEX_BITS-1:0]           next_index;
	logic signed [SAMPLE_BITS-1:0]   s1;
	logic signed [SAMPLE_BITS-1:0]   s2;
	logic signed [SAMPLE_BITS-1:0]   sa_d;
	logic signed [DIFF_BITS-1:0]     diff_d;
	logic [FRACTION_BITS-1:0]        frac_d;
	logic signed [PROD_BITS-1:0]     rounded;

	logic                            valid_s1;
	logic signed [SAMPLE_BITS-1:0]   sa_s1;
	logic signed [DIFF_BITS-1:0]     diff_s1;
	logic [FRACTION_BITS-1:0]        frac_s1;
	logic                            valid_s2;
	logic signed [SAMPLE_BITS-1:0]   sa_s2;
	logic signed [PROD_BITS-1:0]     prod_s2;
	logic                            out_valid_q;
	logic signed [SAMPLE_BITS-1:0]   sample_q;

	function automatic logic signed [SAMPLE_BITS-1:0] sine_lookup(
		input logic [INDEX_BITS-1:0] i);
		logic signed [SAMPLE_BITS-1:0] v;
		v = $signed(SINE_ROM[i[HALF_BITS-1:0]]);
		return i[INDEX_BITS-1] ? -v : v;
	endfunction

	assign en = !out_valid_q || out_ready;
	assign pop = en && !status.empty;

	assign next_index = cmd.index + INDEX_BITS'(1);
	assign s1 = sine_lookup(cmd.index);
	assign s2 = sine_lookup(next_index);

	always_comb begin
		if (cmd.wave == WAVE_NOISE) begin
			sa_d = $signed(cmd.noise);
			diff_d = '0;
			frac_d = '0;
		end else begin
			sa_d = s1;
			diff_d = DIFF_BITS'(s2) - DIFF_BITS'(s1);
			frac_d = cmd.frac;
		end
	end

	assign rounded = (prod_s2 + PROD_BITS'(1 << (FRACTION_BITS - 1))) >>> FRACTION_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= sa_d;
			diff_s1 <= diff_d;
			frac_s1 <= frac_d;
			sa_s2 <= sa_s1;
			prod_s2 <= PROD_BITS'(diff_s1) * PROD_BITS'($signed({1'b0, frac_s1}));
			sample_q <= sa_s2 + rounded[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign sample_value = sample_q;

endmodule

FILE: hw/rtl/table_sine_oscillator_with_noise_top.sv
// A result passes through the command queue, both stage registers and the output register.
// Throughput: one request per cycle while in_ready is high; the output stage is a three-deep
// pipeline with one table read pair and one interpolation multiply, fed through a four-entry
// command queue. A request with a zero bit is taken without producing a result.
// Reset is asynchronous and active low; the sine table is constant and needs no fill.
module table_sine_oscillator_with_noise_top import tso_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          sample_request,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_value
);

	logic          push;
	logic          pop;
	cmd_t          wr_cmd;
	cmd_t          rd_cmd;
	queue_status_t q_status;

	tso_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_request (sample_request),
		.status         (q_status),
		.push           (push),
		.cmd            (wr_cmd)
	);

	tso_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_cmd),
		.pop     (pop),
		.rd_data (rd_cmd),
		.status  (q_status)
	);

	tso_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (rd_cmd),
		.status       (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value)
	);

	a_idle_request_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !sample_request) |-> !push)
		else $error("A request with a zero bit queued a command.");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("Command queue written while full.");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("Command queue read while empty.");

	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !pop)
		else $error("Pipeline advanced while the output was stalled.");

endmodule
